// ===== design/wildcard_byte_pattern_scanner_core_assert.svh =====
// Assertion macros used by the checker file of the byte pattern scanner.
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_CORE_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_CORE_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define WBPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define WBPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/wbps_pkg.sv =====
// Types and constants shared by the byte pattern scanner modules.
package wbps_pkg;

    localparam int WIN         = 16;
    localparam int PAT_BYTES   = 16;
    localparam int MAX_STRIDE  = 4096;
    localparam int HIT_OUT_W   = 13;
    localparam int ADDR_W      = 64;
    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = 2;

    typedef enum logic [2:0] {
        CFG_PATTERN_LOW   = 3'd0,
        CFG_PATTERN_HIGH  = 3'd1,
        CFG_WILDCARD_MASK = 3'd2,
        CFG_PATTERN_LEN   = 3'd3,
        CFG_STRIDE        = 3'd4,
        CFG_PROT_FILTER   = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic [63:0] address;
        logic [7:0]  data_byte;
        logic [7:0]  region_protection;
        logic        region_first;
        logic        scan_last;
    } t_in_item;

    typedef struct packed {
        logic        is_match;
        logic [63:0] match_address;
        logic [12:0] hit_count;
        logic        is_final;
        logic        limit_reached;
    } t_out_item;

    typedef struct packed {
        logic [63:0] pattern_low;
        logic [63:0] pattern_high;
        logic [15:0] wildcard_mask;
        logic [4:0]  pattern_length;
        logic [12:0] stride;
        logic [7:0]  protection_filter;
    } t_cfg;

    // One classified byte on its way from front to back.
    typedef struct packed {
        logic        hit;
        logic [63:0] address;
        logic        last;
    } t_rec;

endpackage

// ===== design/wildcard_byte_pattern_scanner_core.sv =====
// Wildcard byte pattern scanner: takes one memory byte per cycle, while full is
// low, in address order and reports every place where the configured pattern
// (up to 16 bytes, any byte may be a wildcard) starts at a candidate offset,
// that is region start plus a multiple of the stride, inside a region whose
// protection bits share a bit with the protection filter. A match never
// straddles a region boundary. Each result carries the match start address and
// the running hit count; once the count reaches HIT_LIMIT further matches are
// dropped, and the byte marked scan_last always closes the scan with one final
// result and resets the scan state. The block sustains one byte per clock while
// full is low: the front end shifts the byte into its window and compares the
// whole pattern in parallel in the cycle it is taken, then pushes the classified
// byte into a four-entry queue; the back end takes it from the queue, counts hits
// and loads the result register, which drives the outputs. full rises only when
// the queue fills because results are not being popped. Configuration writes
// take effect on the next edge and must happen while the block is idle.
module wildcard_byte_pattern_scanner_core #(
    parameter int MAX_PATTERN = 16,
    parameter int HIT_LIMIT   = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // byte input
    input  logic                push,
    output logic                full,
    input  wbps_pkg::t_in_item  i_item,
    // result output
    output logic                empty,
    input  logic                pop,
    output wbps_pkg::t_out_item o_result,
    // configuration writes
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [63:0]         i_cfg_data
);

    wbps_pkg::t_cfg r_cfg;

    logic           w_accept;
    wbps_pkg::t_rec w_front_rec;
    wbps_pkg::t_rec w_back_rec;
    logic           w_q_empty;
    logic           w_take;

    // A byte transfers whenever the queue has room.
    assign w_accept = push && !full;

    // Configuration registers; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_low       <= 64'd0;
            r_cfg.pattern_high      <= 64'd0;
            r_cfg.wildcard_mask     <= 16'd0;
            r_cfg.pattern_length    <= 5'd1;
            r_cfg.stride            <= 13'd1;
            r_cfg.protection_filter <= 8'hFF;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                wbps_pkg::CFG_PATTERN_LOW:   r_cfg.pattern_low       <= i_cfg_data;
                wbps_pkg::CFG_PATTERN_HIGH:  r_cfg.pattern_high      <= i_cfg_data;
                wbps_pkg::CFG_WILDCARD_MASK: r_cfg.wildcard_mask     <= i_cfg_data[15:0];
                wbps_pkg::CFG_PATTERN_LEN:   r_cfg.pattern_length    <= i_cfg_data[4:0];
                wbps_pkg::CFG_STRIDE:        r_cfg.stride            <= i_cfg_data[12:0];
                wbps_pkg::CFG_PROT_FILTER:   r_cfg.protection_filter <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Front: window, candidate marks, pattern compare.
    wbps_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_accept (w_accept),
        .i_item   (i_item),
        .o_rec    (w_front_rec)
    );

    // Queue decouples the compare from result delivery.
    wbps_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_wdata (w_front_rec),
        .o_full  (full),
        .i_rd    (w_take),
        .o_rdata (w_back_rec),
        .o_empty (w_q_empty)
    );

    // Back: hit count, limit stop, result register.
    wbps_back #(
        .HIT_LIMIT (HIT_LIMIT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (!w_q_empty),
        .i_rec       (w_back_rec),
        .o_rec_take  (w_take),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

endmodule

// ===== design/wbps_fifo.sv =====
// Short queue of classified bytes between the front and back of the scanner.
module wbps_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  wbps_pkg::t_rec i_wdata,
    output logic           o_full,
    input  logic           i_rd,
    output wbps_pkg::t_rec o_rdata,
    output logic           o_empty
);

    wbps_pkg::t_rec              r_mem [wbps_pkg::Q_DEPTH];
    logic [wbps_pkg::Q_AW:0]     r_wr_ptr;
    logic [wbps_pkg::Q_AW:0]     r_rd_ptr;

    assign o_empty = (r_wr_ptr == r_rd_ptr);
    assign o_full  = (r_wr_ptr[wbps_pkg::Q_AW] != r_rd_ptr[wbps_pkg::Q_AW]) &&
                     (r_wr_ptr[wbps_pkg::Q_AW-1:0] == r_rd_ptr[wbps_pkg::Q_AW-1:0]);
    assign o_rdata = r_mem[r_rd_ptr[wbps_pkg::Q_AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_wr && !o_full) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_rd && !o_empty) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr && !o_full) begin
            r_mem[r_wr_ptr[wbps_pkg::Q_AW-1:0]] <= i_wdata;
        end
    end

endmodule

// ===== design/wbps_front.sv =====
// Front end: byte window, candidate marks and the parallel pattern compare.
module wbps_front #(
    parameter int MAX_PATTERN = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wbps_pkg::t_cfg     i_cfg,
    input  logic               i_accept,
    input  wbps_pkg::t_in_item i_item,
    output wbps_pkg::t_rec     o_rec
);

    localparam int D  = (MAX_PATTERN < wbps_pkg::WIN) ? MAX_PATTERN : wbps_pkg::WIN;
    localparam int LW = $clog2(D + 1);
    localparam int IW = (D > 1) ? $clog2(D) : 1;

    logic [7:0]    r_window [D];
    logic [D-1:0]  r_cand;
    logic [LW-1:0] r_fill;
    logic [11:0]   r_phase;

    logic [7:0]    w_win [D];
    logic [D-1:0]  w_candv;
    logic [7:0]    w_pat [wbps_pkg::PAT_BYTES];
    logic [3:0]    w_k [D];
    logic [LW-1:0] w_len;
    logic [12:0]   w_stride;
    logic [11:0]   w_phase_base;
    logic [12:0]   w_phase_inc;
    logic [11:0]   n_phase;
    logic [LW-1:0] w_fill_base;
    logic [LW-1:0] n_fill;
    logic          w_cand_new;
    logic          w_ok;
    logic          w_hit;

    // Clamp length and stride into their legal ranges.
    always_comb begin
        if (i_cfg.pattern_length == 5'd0) begin
            w_len = LW'(1);
        end else if (i_cfg.pattern_length > 5'(D)) begin
            w_len = LW'(D);
        end else begin
            w_len = LW'(i_cfg.pattern_length);
        end
        if (i_cfg.stride == 13'd0) begin
            w_stride = 13'd1;
        end else if (i_cfg.stride > 13'(wbps_pkg::MAX_STRIDE)) begin
            w_stride = 13'(wbps_pkg::MAX_STRIDE);
        end else begin
            w_stride = i_cfg.stride;
        end
    end

    // Region bookkeeping for the incoming byte.
    always_comb begin
        w_phase_base = i_item.region_first ? 12'd0 : r_phase;
        w_fill_base  = i_item.region_first ? '0 : r_fill;
        w_cand_new   = (w_phase_base == 12'd0) &&
                       ((i_item.region_protection & i_cfg.protection_filter) != 8'd0);
        w_phase_inc  = {1'b0, w_phase_base} + 13'd1;
        n_phase      = (w_phase_inc >= w_stride) ? 12'd0 : w_phase_inc[11:0];
        n_fill       = (w_fill_base < LW'(D)) ? w_fill_base + LW'(1) : w_fill_base;
    end

    // Window after the new byte shifts in; slot 0 holds the newest byte.
    always_comb begin
        w_win[0]   = i_item.data_byte;
        w_candv[0] = w_cand_new;
        for (int j = 1; j < D; j++) begin
            w_win[j]   = r_window[j-1];
            w_candv[j] = r_cand[j-1];
        end
    end

    // Compare every used, non-wildcard pattern byte against its window slot.
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            w_pat[k]     = i_cfg.pattern_low[8*k +: 8];
            w_pat[k + 8] = i_cfg.pattern_high[8*k +: 8];
        end
        w_ok = 1'b1;
        for (int j = 0; j < D; j++) begin
            w_k[j] = 4'(5'(w_len) - 5'(j) - 5'd1);
            if ((5'(j) < 5'(w_len)) && !i_cfg.wildcard_mask[w_k[j]] &&
                (w_win[j] != w_pat[w_k[j]])) begin
                w_ok = 1'b0;
            end
        end
        w_hit = w_ok && (n_fill >= w_len) && w_candv[IW'(w_len - LW'(1))];
    end

    assign o_rec.hit     = w_hit;
    assign o_rec.address = i_item.address - (64'(w_len) - 64'd1);
    assign o_rec.last    = i_item.scan_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand  <= '0;
            r_fill  <= '0;
            r_phase <= '0;
        end else if (i_accept) begin
            if (i_item.scan_last) begin
                r_cand  <= '0;
                r_fill  <= '0;
                r_phase <= '0;
            end else begin
                r_cand  <= w_candv;
                r_fill  <= n_fill;
                r_phase <= n_phase;
            end
        end
    end

    // Window bytes are only read inside the fill count, so they need no clear.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            for (int j = 0; j < D; j++) begin
                r_window[j] <= w_win[j];
            end
        end
    end

endmodule

// ===== design/wbps_back.sv =====
// Back end: hit counting, scan stop and the result output register.
module wbps_back #(
    parameter int HIT_LIMIT = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rec_valid,
    input  wbps_pkg::t_rec      i_rec,
    output logic                o_rec_take,
    input  logic                i_pop,
    output logic                o_empty,
    output wbps_pkg::t_out_item o_result
);

    localparam int CW0 = $clog2(HIT_LIMIT + 1);
    localparam int CW  = (CW0 > wbps_pkg::HIT_OUT_W) ? CW0 : wbps_pkg::HIT_OUT_W;

    logic [CW-1:0]       r_hits;
    logic                r_stopped;
    logic                r_out_valid;
    wbps_pkg::t_out_item r_out;

    logic                w_hit;
    logic [CW-1:0]       n_hits;
    logic                w_lim;
    logic                w_emit;

    assign o_rec_take = i_rec_valid && (!r_out_valid || i_pop);
    assign w_hit      = i_rec.hit && !r_stopped;
    assign n_hits     = w_hit ? r_hits + CW'(1) : r_hits;
    assign w_lim      = (n_hits >= CW'(HIT_LIMIT));
    assign w_emit     = w_hit || i_rec.last;

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits      <= '0;
            r_stopped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_rec_take) begin
                if (i_rec.last) begin
                    r_hits    <= '0;
                    r_stopped <= 1'b0;
                end else begin
                    r_hits    <= n_hits;
                    r_stopped <= r_stopped || w_lim;
                end
            end
            if (o_rec_take && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rec_take && w_emit) begin
            r_out.is_match      <= w_hit;
            r_out.match_address <= w_hit ? i_rec.address : 64'd0;
            r_out.hit_count     <= n_hits[wbps_pkg::HIT_OUT_W-1:0];
            r_out.is_final      <= i_rec.last;
            r_out.limit_reached <= w_lim;
        end
    end

endmodule

// ===== design/wbps_checker.sv =====
// Port-level assertions for the byte pattern scanner and their bind.
`include "wildcard_byte_pattern_scanner_core_assert.svh"

module wbps_checker #(
    parameter int HIT_LIMIT = 4096
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                empty,
    input logic                pop,
    input wbps_pkg::t_out_item o_result
);

    // A result exists only for a match or for the closing byte.
    `WBPS_ASSERT_NOW(a_result_has_cause, i_clk, i_rst_n, !empty, o_result.is_match || o_result.is_final, "result with neither match nor final")

    // No match means no address.
    `WBPS_ASSERT_NOW(a_addr_zero_no_match, i_clk, i_rst_n, !empty && !o_result.is_match, o_result.match_address == 64'd0, "address set without a match")

    // The count stops exactly at the limit.
    `WBPS_ASSERT_NOW(a_limit_count, i_clk, i_rst_n, !empty && o_result.limit_reached, o_result.hit_count == 13'(HIT_LIMIT), "limit flag with wrong hit count")

    // Hold a waiting result until it transfers.
    `WBPS_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_result), "waiting result changed")

endmodule

bind wildcard_byte_pattern_scanner_core wbps_checker #(
    .HIT_LIMIT (HIT_LIMIT)
) u_wbps_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);

// ===== dv/wildcard_byte_pattern_scanner_core_test.sv =====
// Self-checking testbench for the wildcard byte pattern scanner core.
`timescale 1ns / 1ps

module wildcard_byte_pattern_scanner_core_test;

    import wbps_pkg::*;

    localparam int MAX_PATTERN     = 16;
    localparam int HIT_LIMIT       = 4096;
    // Results pass through the queue, which holds four, and the result register.
    localparam int DRAIN_CYCLES    = 8;
    localparam int QUIET_LIMIT     = 3000;
    localparam int RANDOM_PER_MODE = 634;

    // Pattern used by the directed rows: byte k sits in bits 8k+7..8k.
    localparam logic [63:0] DIR_PAT_LOW  = 64'hC3FF_003F_7E81_0102;
    localparam logic [63:0] DIR_PAT_HIGH = 64'h0055_AA3F_FF00_1234;

    // One row of the directed table: a register write or one byte transfer.
    // A pinned row carries its expected result typed in by hand.
    typedef struct {
        bit          is_cfg;
        t_cfg_index  reg_idx;
        logic [63:0] reg_data;
        t_in_item    item;
        bit          pinned;
        bit          pin_some;
        t_out_item   pin_res;
    } plan_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    t_in_item    i_item;
    logic        empty;
    logic        pop;
    t_out_item   o_result;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    // Shadow of the configuration registers and of the scan state.
    t_cfg        scan_cfg;
    logic [7:0]  seen_bytes [WIN];
    bit          seen_cand [WIN];
    int unsigned region_seen;
    int unsigned phase_count;
    int unsigned match_total;
    bit          scan_halted;

    t_out_item   pending_results [$];
    int unsigned mismatches;
    int unsigned quiet_cycles;
    int unsigned send_idle_pct;
    int unsigned take_idle_pct;

    wildcard_byte_pattern_scanner_core #(
        .MAX_PATTERN (MAX_PATTERN),
        .HIT_LIMIT   (HIT_LIMIT)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void clear_scan();
        int i;
        for (i = 0; i < WIN; i++) begin
            seen_bytes[i] = 8'h00;
            seen_cand[i]  = 1'b0;
        end
        region_seen = 0;
        phase_count = 0;
        match_total = 0;
        scan_halted = 1'b0;
    endfunction

    // Pattern length in force: zero counts as one, long values saturate.
    function automatic int unsigned eff_len();
        int unsigned n;
        n = scan_cfg.pattern_length;
        if (n == 0) n = 1;
        if (n > MAX_PATTERN) n = MAX_PATTERN;
        if (n > WIN) n = WIN;
        return n;
    endfunction

    function automatic int unsigned eff_stride();
        int unsigned s;
        s = scan_cfg.stride;
        if (s == 0) s = 1;
        if (s > MAX_STRIDE) s = MAX_STRIDE;
        return s;
    endfunction

    function automatic logic [7:0] pat_byte(int unsigned k);
        logic [127:0] both;
        both = {scan_cfg.pattern_high, scan_cfg.pattern_low};
        return both[8*k +: 8];
    endfunction

    // Mirror a register write, keeping only the bits the register holds.
    function automatic void apply_reg(t_cfg_index idx, logic [63:0] d);
        case (idx)
            CFG_PATTERN_LOW:   scan_cfg.pattern_low       = d;
            CFG_PATTERN_HIGH:  scan_cfg.pattern_high      = d;
            CFG_WILDCARD_MASK: scan_cfg.wildcard_mask     = d[15:0];
            CFG_PATTERN_LEN:   scan_cfg.pattern_length    = d[4:0];
            CFG_STRIDE:        scan_cfg.stride            = d[12:0];
            CFG_PROT_FILTER:   scan_cfg.protection_filter = d[7:0];
            default: ;
        endcase
    endfunction

    // Advance the scan by one byte; return 1 when the byte yields a result.
    function automatic bit predict_scan_result(input t_in_item it, output t_out_item res);
        int unsigned n, s, k;
        int          i;
        bit          pass, hit;
        hit = 1'b0;
        res = '0;
        n   = eff_len();
        s   = eff_stride();
        if (!scan_halted) begin
            pass = (it.region_protection & scan_cfg.protection_filter) != 8'h00;
            if (it.region_first) begin
                region_seen = 0;
                phase_count = 0;
            end
            for (i = WIN - 1; i > 0; i--) begin
                seen_bytes[i] = seen_bytes[i-1];
                seen_cand[i]  = seen_cand[i-1];
            end
            seen_bytes[0] = it.data_byte;
            seen_cand[0]  = (phase_count == 0) && pass;
            if (region_seen < WIN) region_seen++;
            phase_count++;
            if (phase_count >= s) phase_count = 0;
            // The window start must be a candidate and lie in this region.
            if (region_seen >= n && seen_cand[n-1]) begin
                hit = 1'b1;
                for (k = 0; k < n; k++) begin
                    if (!scan_cfg.wildcard_mask[k] && seen_bytes[n-1-k] != pat_byte(k))
                        hit = 1'b0;
                end
            end
            if (hit) begin
                res.match_address = it.address - 64'(n - 1);
                match_total++;
                if (match_total >= HIT_LIMIT) scan_halted = 1'b1;
            end
        end
        if (!hit && !it.scan_last) return 1'b0;
        res.is_match      = hit;
        res.hit_count     = match_total[12:0];
        res.is_final      = it.scan_last;
        res.limit_reached = match_total >= HIT_LIMIT;
        if (it.scan_last) clear_scan();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Directed table helpers
    // ------------------------------------------------------------------

    function automatic plan_row_t cfg_row(t_cfg_index idx, logic [63:0] d);
        plan_row_t row;
        row          = '{reg_idx: CFG_PATTERN_LOW, default: '0};
        row.is_cfg   = 1'b1;
        row.reg_idx  = idx;
        row.reg_data = d;
        return row;
    endfunction

    function automatic plan_row_t byte_row(logic [63:0] a, logic [7:0] d, logic [7:0] p,
                                           bit first, bit last);
        plan_row_t row;
        row                          = '{reg_idx: CFG_PATTERN_LOW, default: '0};
        row.reg_idx                  = CFG_PATTERN_LOW;
        row.item.address             = a;
        row.item.data_byte           = d;
        row.item.region_protection   = p;
        row.item.region_first        = first;
        row.item.scan_last           = last;
        return row;
    endfunction

    // Fix the expectation of a row: no result, or the result given.
    function automatic plan_row_t pin(plan_row_t row, bit some, bit m, logic [63:0] a,
                                      int unsigned hits, bit fin);
        row.pinned                = 1'b1;
        row.pin_some              = some;
        row.pin_res               = '0;
        row.pin_res.is_match      = m;
        row.pin_res.match_address = a;
        row.pin_res.hit_count     = 13'(hits);
        row.pin_res.is_final      = fin;
        return row;
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Hold the byte on the input until the block takes it, then log what
    // the transfer must produce.
    task automatic send_item(input t_in_item it, input bit pinned, input bit pin_some,
                             input t_out_item pin_res);
        t_out_item r;
        bit        got;
        i_cfg_we <= 1'b0;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        got = predict_scan_result(it, r);
        if (pinned) begin
            got = pin_some;
            r   = pin_res;
        end
        if (got) pending_results.push_back(r);
    endtask

    // Write one register; the caller's next byte transfer drops the enable.
    task automatic write_reg(input t_cfg_index idx, input logic [63:0] d);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        apply_reg(idx, d);
    endtask

    // Drain every pending result, then give the block time to go idle:
    // bytes without a result may still be in flight.
    task automatic settle();
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Sometimes set bits above the register width; the block must drop them.
    function automatic logic [63:0] with_junk(logic [63:0] v, int w);
        if ($urandom_range(3) == 0) return ({$urandom, $urandom} << w) | v;
        return v;
    endfunction

    // Pick a new setting, leaning on the saturating and extreme values.
    task automatic new_settings();
        logic [4:0]  len;
        logic [12:0] str;
        logic [15:0] wm;
        logic [7:0]  filt;
        case ($urandom_range(9))
            0:       len = 5'd0;
            1:       len = 5'd16;
            2:       len = 5'($urandom_range(31, 17));
            default: len = 5'($urandom_range(6, 1));
        endcase
        case ($urandom_range(9))
            0:       str = 13'd0;
            1:       str = 13'd4096;
            2:       str = 13'($urandom_range(8191, 4097));
            3:       str = 13'($urandom_range(40, 5));
            default: str = 13'($urandom_range(4, 1));
        endcase
        case ($urandom_range(3))
            0, 1:    wm = 16'h0000;
            2:       wm = 16'h0001 << $urandom_range(15);
            default: wm = 16'($urandom);
        endcase
        case ($urandom_range(7))
            0:       filt = 8'h00;
            1:       filt = 8'hFF;
            default: filt = 8'($urandom);
        endcase
        write_reg(CFG_PATTERN_LOW, {$urandom, $urandom});
        write_reg(CFG_PATTERN_HIGH, {$urandom, $urandom});
        write_reg(CFG_WILDCARD_MASK, with_junk(64'(wm), 16));
        write_reg(CFG_PATTERN_LEN, with_junk(64'(len), 5));
        write_reg(CFG_STRIDE, with_junk(64'(str), 13));
        write_reg(CFG_PROT_FILTER, with_junk(64'(filt), 8));
    endtask

    // One scan: a few regions of consecutive addresses, with the pattern
    // planted at many candidate offsets, some copies damaged, and a few
    // stray bytes mixed in. The last byte closes the scan.
    task automatic run_scan(inout int unsigned sent);
        logic [63:0] addr;
        logic [7:0]  rb [48];
        logic [7:0]  prot;
        t_in_item    it;
        int unsigned n, s, o, k, j, hi, len_r, nreg, r;
        n = eff_len();
        s = eff_stride();
        case ($urandom_range(3))
            0:       addr = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(40));
            1:       addr = 64'($urandom_range(40));
            default: addr = {$urandom, $urandom};
        endcase
        nreg = $urandom_range(4, 1);
        for (r = 0; r < nreg; r++) begin
            hi = 3 * n + 8;
            if (hi > 47) hi = 47;
            if ($urandom_range(9) < 7) len_r = $urandom_range(hi, n);
            else len_r = $urandom_range(47, 1);
            prot = 8'($urandom);
            if ($urandom_range(9) < 7 && (prot & scan_cfg.protection_filter) == 8'h00)
                prot = prot | (scan_cfg.protection_filter & (~scan_cfg.protection_filter + 8'd1));
            for (j = 0; j < len_r; j++) rb[j] = 8'($urandom);
            for (o = 0; o + n <= len_r; o += s) begin
                if ($urandom_range(1) == 1) begin
                    for (k = 0; k < n; k++)
                        rb[o+k] = scan_cfg.wildcard_mask[k] ? 8'($urandom) : pat_byte(k);
                    if ($urandom_range(4) == 0) begin
                        j     = o + $urandom_range(n - 1);
                        rb[j] = rb[j] ^ (8'h01 << $urandom_range(7));
                    end
                end
            end
            for (j = 0; j < len_r; j++) begin
                it.address           = addr;
                it.data_byte         = rb[j];
                it.region_protection = prot;
                it.region_first      = (j == 0) && ($urandom_range(9) != 0);
                it.scan_last         = (r == nreg - 1) && (j == len_r - 1);
                if ($urandom_range(99) < 5) begin
                    it.address           = {$urandom, $urandom};
                    it.data_byte         = 8'($urandom);
                    it.region_protection = 8'($urandom);
                    it.region_first      = 1'($urandom);
                end
                send_item(it, 1'b0, 1'b0, '0);
                sent++;
                addr++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: pop at random, compare each transfer with the oldest
    // pending expectation.
    // ------------------------------------------------------------------

    initial begin
        t_out_item want, got;
        pop <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            pop <= !(take_idle_pct != 0 && $urandom_range(99) < take_idle_pct);
            @(posedge i_clk);
            if (pop && !empty) begin
                got = o_result;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: match=%0b addr=%h hits=%0d final=%0b limit=%0b",
                                 got.is_match, got.match_address, got.hit_count,
                                 got.is_final, got.limit_reached);
                end else begin
                    want = pending_results.pop_front();
                    if (got.is_match !== want.is_match ||
                        got.match_address !== want.match_address ||
                        got.hit_count !== want.hit_count ||
                        got.is_final !== want.is_final ||
                        got.limit_reached !== want.limit_reached) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result mismatch: expected match=%0b addr=%h hits=%0d final=%0b limit=%0b",
                                     want.is_match, want.match_address, want.hit_count,
                                     want.is_final, want.limit_reached);
                            $display("                 actual   match=%0b addr=%h hits=%0d final=%0b limit=%0b",
                                     got.is_match, got.match_address, got.hit_count,
                                     got.is_final, got.limit_reached);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial begin
        plan_row_t    plan [$];
        logic [127:0] dir_pat;
        logic [63:0]  base;
        int unsigned  sent;
        int           mode, k, i;
        int unsigned  send_idle_by_mode [3];
        int unsigned  take_idle_by_mode [3];

        send_idle_by_mode = '{31, 86, 0};
        take_idle_by_mode = '{86, 31, 0};
        mismatches    = 0;
        quiet_cycles  = 0;
        send_idle_pct = send_idle_by_mode[0];
        take_idle_pct = take_idle_by_mode[0];

        push        <= 1'b0;
        i_item      <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_PATTERN_LOW;
        i_cfg_data  <= '0;
        i_rst_n     <= 1'b0;

        // Register values after reset.
        scan_cfg                   = '0;
        scan_cfg.pattern_length    = 5'd1;
        scan_cfg.stride            = 13'd1;
        scan_cfg.protection_filter = 8'hFF;
        clear_scan();

        // Reset config: a lone 0x00 byte matches at every passing byte.
        plan.push_back(pin(byte_row(64'd0, 8'h00, 8'h01, 1'b1, 1'b0),
                           1'b1, 1'b1, 64'd0, 1, 1'b0));
        plan.push_back(pin(byte_row(64'd1, 8'hFF, 8'h80, 1'b0, 1'b0),
                           1'b0, 1'b0, 64'd0, 0, 1'b0));
        // Protection fails the filter: never a candidate.
        plan.push_back(pin(byte_row(64'd2, 8'h00, 8'h00, 1'b1, 1'b0),
                           1'b0, 1'b0, 64'd0, 0, 1'b0));
        plan.push_back(pin(byte_row(64'd3, 8'h00, 8'h00, 1'b0, 1'b1),
                           1'b1, 1'b0, 64'd0, 1, 1'b1));

        // Full 16-byte pattern, first and last byte wildcards, length and
        // stride out of range, no region mark at scan start, addresses
        // wrapping past the top.
        plan.push_back(cfg_row(CFG_PATTERN_LOW, DIR_PAT_LOW));
        plan.push_back(cfg_row(CFG_PATTERN_HIGH, DIR_PAT_HIGH));
        plan.push_back(cfg_row(CFG_WILDCARD_MASK, 64'h8001));
        plan.push_back(cfg_row(CFG_PATTERN_LEN, 64'd31));
        plan.push_back(cfg_row(CFG_STRIDE, 64'd0));
        plan.push_back(cfg_row(CFG_PROT_FILTER, 64'h80));
        dir_pat = {DIR_PAT_HIGH, DIR_PAT_LOW};
        base    = 64'hFFFF_FFFF_FFFF_FFF8;
        for (k = 0; k < 16; k++) begin
            if (k == 15) begin
                plan.push_back(pin(byte_row(base + 64'(k), 8'hA5, 8'hC0, 1'b0, 1'b1),
                                   1'b1, 1'b1, base, 1, 1'b1));
            end else begin
                plan.push_back(byte_row(base + 64'(k), (k == 0) ? 8'h5A : dir_pat[8*k +: 8],
                                        8'hC0, 1'b0, 1'b0));
            end
        end

        // Two-byte pattern 02 01, stride saturated; then the same pair
        // split across a region boundary must not match.
        plan.push_back(cfg_row(CFG_WILDCARD_MASK, 64'h0));
        plan.push_back(cfg_row(CFG_PATTERN_LEN, 64'd2));
        plan.push_back(cfg_row(CFG_STRIDE, 64'd8191));
        plan.push_back(pin(byte_row(64'd100, 8'h02, 8'h81, 1'b1, 1'b0),
                           1'b0, 1'b0, 64'd0, 0, 1'b0));
        plan.push_back(pin(byte_row(64'd101, 8'h01, 8'h81, 1'b0, 1'b0),
                           1'b1, 1'b1, 64'd100, 1, 1'b0));
        plan.push_back(pin(byte_row(64'd102, 8'h02, 8'h81, 1'b1, 1'b0),
                           1'b0, 1'b0, 64'd0, 0, 1'b0));
        plan.push_back(pin(byte_row(64'd103, 8'h01, 8'h81, 1'b1, 1'b0),
                           1'b0, 1'b0, 64'd0, 0, 1'b0));
        plan.push_back(pin(byte_row(64'd104, 8'h02, 8'h81, 1'b0, 1'b1),
                           1'b1, 1'b0, 64'd0, 1, 1'b1));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (mode = 0; mode < 3; mode++) begin
            send_idle_pct = send_idle_by_mode[mode];
            take_idle_pct = take_idle_by_mode[mode];

            if (mode == 0) begin
                for (i = 0; i < plan.size(); i++) begin
                    if (plan[i].is_cfg) begin
                        if (i == 0 || !plan[i-1].is_cfg) settle();
                        write_reg(plan[i].reg_idx, plan[i].reg_data);
                    end else begin
                        send_item(plan[i].item, plan[i].pinned, plan[i].pin_some,
                                  plan[i].pin_res);
                    end
                end
            end

            settle();
            new_settings();
            sent = 0;
            while (sent < RANDOM_PER_MODE) begin
                run_scan(sent);
                if ($urandom_range(9) < 3) begin
                    settle();
                    new_settings();
                end
            end
        end

        // Wait for the last results, then allow for stragglers.
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES * 2) @(posedge i_clk);

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
